// ----- rtl/wavhp_pkg.sv -----
// Shared constants and control/status types for the WAV header parser and sample unpacker.
package wavhp_pkg;

	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FMT  = 32'h666d_7420;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;
	localparam logic [15:0] TAG_PCM = 16'h0001;
	localparam logic [15:0] TAG_EXT = 16'hFFFE;
	localparam logic [7:0]  LIMIT_RESET = 8'd20;
	localparam logic [7:0]  SMP_FLIP = 8'h80;
	localparam logic [7:0]  SMP_FILL = 8'h7f;
	localparam logic [32:0] RECIP3 = 33'h0_AAAA_AAAB;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HDR    = 2'd1;
	localparam logic [1:0] KIND_REJ    = 2'd2;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NOT_RIFF  = 4'd1;
	localparam logic [3:0] ERR_NOT_WAVE  = 4'd2;
	localparam logic [3:0] ERR_FMT_SHORT = 4'd3;
	localparam logic [3:0] ERR_BAD_SIZE  = 4'd4;
	localparam logic [3:0] ERR_NO_DATA   = 4'd5;
	localparam logic [3:0] ERR_CHANNELS  = 4'd6;
	localparam logic [3:0] ERR_BITS      = 4'd7;
	localparam logic [3:0] ERR_NOT_PCM   = 4'd8;

	typedef struct packed {
		logic       acc;
		logic       big;
		logic       done;
		logic [2:0] pos;
		logic       restart;
		logic       ld_tag;
		logic       ld_ch;
		logic       ld_rate;
		logic       ld_avg;
		logic       ld_align;
		logic       ld_bits;
		logic       ld_fmtrem;
		logic       sub10;
		logic       skip_from_fmt;
		logic       skip_from_size;
		logic       dec_skip;
		logic       clr_chunks;
		logic       inc_chunks;
		logic       smp_acc;
		logic       emit_smp;
		logic       emit_rej;
		logic [3:0] err;
		logic       ld_len;
		logic       mul;
		logic       emit_hdr;
	} cmd_t;

	typedef struct packed {
		logic       is_riff;
		logic       is_wave;
		logic       is_fmt;
		logic       is_data;
		logic       w_msb;
		logic       fmt_short;
		logic       ext_ok;
		logic       fmt_zero;
		logic       w_zero;
		logic       skip_last;
		logic       chunk_hit;
		logic       limit_zero;
		logic [3:0] hdr_err;
		logic [2:0] smp_n;
		logic       out_free;
	} sts_t;

endpackage

// ----- rtl/wavhp_in_if.sv -----
// Byte stream channel.
interface wavhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;
	modport source(output valid, output data_byte, output start_of_file, input ready);
	modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

// ----- rtl/wavhp_out_if.sv -----
// Result channel.
interface wavhp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [3:0]         error_code;
	logic signed [31:0] sample_value;
	logic [1:0]         channel_count;
	logic [5:0]         sample_bits;
	logic [31:0]        sample_rate;
	logic [31:0]        avg_byte_rate;
	logic [15:0]        block_alignment;
	logic [31:0]        data_length;
	logic [31:0]        sample_count;
	modport source(output valid, output result_kind, output error_code, output sample_value,
		output channel_count, output sample_bits, output sample_rate, output avg_byte_rate,
		output block_alignment, output data_length, output sample_count, input ready);
	modport sink(input valid, input result_kind, input error_code, input sample_value,
		input channel_count, input sample_bits, input sample_rate, input avg_byte_rate,
		input block_alignment, input data_length, input sample_count, output ready);
endinterface

// ----- rtl/wavhp_ctrl.sv -----
// Parse-phase state machine: walks the RIFF structure and issues datapath commands.
module wavhp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             sof,
	input  wavhp_pkg::sts_t  sts,
	output wavhp_pkg::cmd_t  cmd,
	output logic             busy
);

	localparam logic [4:0] PH_RIFF     = 5'd0;
	localparam logic [4:0] PH_FLEN     = 5'd1;
	localparam logic [4:0] PH_WAVE     = 5'd2;
	localparam logic [4:0] PH_ID       = 5'd3;
	localparam logic [4:0] PH_FMTSIZE  = 5'd4;
	localparam logic [4:0] PH_TAG      = 5'd5;
	localparam logic [4:0] PH_CH       = 5'd6;
	localparam logic [4:0] PH_RATE     = 5'd7;
	localparam logic [4:0] PH_AVG      = 5'd8;
	localparam logic [4:0] PH_ALIGN    = 5'd9;
	localparam logic [4:0] PH_BITS     = 5'd10;
	localparam logic [4:0] PH_EXTSKIP  = 5'd11;
	localparam logic [4:0] PH_EXTTAG   = 5'd12;
	localparam logic [4:0] PH_SKIPSIZE = 5'd13;
	localparam logic [4:0] PH_SKIP     = 5'd14;
	localparam logic [4:0] PH_DATASIZE = 5'd15;
	localparam logic [4:0] PH_SAMPLES  = 5'd16;
	localparam logic [4:0] PH_HALT     = 5'd17;
	localparam logic [4:0] PH_DIV1     = 5'd18;
	localparam logic [4:0] PH_DIV2     = 5'd19;

	logic [4:0] phase_q, phase_d, ph;
	logic [2:0] pos_q, pos_d, pos;
	logic [3:0] need, pos_inc;
	logic       done;

	always_comb begin
		ph = (go && sof) ? PH_RIFF : phase_q;
		pos = (go && sof) ? 3'd0 : pos_q;
		pos_inc = {1'b0, pos} + 4'd1;
		unique case (ph)
			PH_TAG, PH_CH, PH_ALIGN, PH_BITS, PH_EXTTAG: need = 4'd2;
			default: need = 4'd4;
		endcase
		done = pos_inc >= need;
		busy = (phase_q == PH_DIV1) || (phase_q == PH_DIV2);

		cmd = '0;
		cmd.pos = pos;
		cmd.restart = go && sof;
		cmd.big = (ph == PH_RIFF) || (ph == PH_WAVE) || (ph == PH_ID);
		phase_d = phase_q;
		pos_d = pos_q;

		unique case (ph)
			PH_DIV1: begin
				cmd.mul = 1'b1;
				phase_d = PH_DIV2;
			end
			PH_DIV2: begin
				if (sts.out_free) begin
					cmd.emit_hdr = 1'b1;
					phase_d = PH_SAMPLES;
					pos_d = 3'd0;
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			PH_EXTSKIP: begin
				if (go) begin
					pos_d = pos + 3'd1;
					phase_d = (pos == 3'd7) ? PH_EXTTAG : PH_EXTSKIP;
				end
			end
			PH_SKIP: begin
				if (go) begin
					cmd.dec_skip = 1'b1;
					phase_d = PH_SKIP;
					if (sts.skip_last) begin
						cmd.inc_chunks = 1'b1;
						if (sts.chunk_hit) begin
							cmd.emit_rej = 1'b1;
							cmd.err = wavhp_pkg::ERR_NO_DATA;
							phase_d = PH_HALT;
						end else begin
							phase_d = PH_ID;
						end
					end
				end
			end
			PH_SAMPLES: begin
				phase_d = PH_SAMPLES;
				if (go) begin
					if ({1'b0, pos} + 4'd1 < {1'b0, sts.smp_n}) begin
						cmd.smp_acc = 1'b1;
						pos_d = pos + 3'd1;
					end else begin
						cmd.emit_smp = 1'b1;
						pos_d = 3'd0;
					end
				end
			end
			default: begin
				phase_d = ph;
				if (go) begin
					cmd.acc = 1'b1;
					cmd.done = done;
					pos_d = done ? 3'd0 : pos + 3'd1;
					if (done) begin
						unique case (ph)
							PH_RIFF: begin
								if (!sts.is_riff) begin
									cmd.emit_rej = 1'b1;
									cmd.err = wavhp_pkg::ERR_NOT_RIFF;
									phase_d = PH_HALT;
								end else begin
									phase_d = PH_FLEN;
								end
							end
							PH_FLEN: phase_d = PH_WAVE;
							PH_WAVE: begin
								cmd.clr_chunks = 1'b1;
								if (!sts.is_wave) begin
									cmd.emit_rej = 1'b1;
									cmd.err = wavhp_pkg::ERR_NOT_WAVE;
									phase_d = PH_HALT;
								end else if (sts.limit_zero) begin
									cmd.emit_rej = 1'b1;
									cmd.err = wavhp_pkg::ERR_NO_DATA;
									phase_d = PH_HALT;
								end else begin
									phase_d = PH_ID;
								end
							end
							PH_ID: begin
								if (sts.is_fmt) phase_d = PH_FMTSIZE;
								else if (sts.is_data) phase_d = PH_DATASIZE;
								else phase_d = PH_SKIPSIZE;
							end
							PH_FMTSIZE: begin
								if (sts.w_msb || sts.fmt_short) begin
									cmd.emit_rej = 1'b1;
									cmd.err = wavhp_pkg::ERR_FMT_SHORT;
									phase_d = PH_HALT;
								end else begin
									cmd.ld_fmtrem = 1'b1;
									phase_d = PH_TAG;
								end
							end
							PH_TAG: begin
								cmd.ld_tag = 1'b1;
								phase_d = PH_CH;
							end
							PH_CH: begin
								cmd.ld_ch = 1'b1;
								phase_d = PH_RATE;
							end
							PH_RATE: begin
								cmd.ld_rate = 1'b1;
								phase_d = PH_AVG;
							end
							PH_AVG: begin
								cmd.ld_avg = 1'b1;
								phase_d = PH_ALIGN;
							end
							PH_ALIGN: begin
								cmd.ld_align = 1'b1;
								phase_d = PH_BITS;
							end
							PH_BITS, PH_EXTTAG: begin
								if (ph == PH_BITS) cmd.ld_bits = 1'b1;
								else cmd.ld_tag = 1'b1;
								if (ph == PH_BITS && sts.ext_ok) begin
									cmd.sub10 = 1'b1;
									phase_d = PH_EXTSKIP;
								end else begin
									cmd.skip_from_fmt = 1'b1;
									if (!sts.fmt_zero) begin
										phase_d = PH_SKIP;
									end else begin
										cmd.inc_chunks = 1'b1;
										if (sts.chunk_hit) begin
											cmd.emit_rej = 1'b1;
											cmd.err = wavhp_pkg::ERR_NO_DATA;
											phase_d = PH_HALT;
										end else begin
											phase_d = PH_ID;
										end
									end
								end
							end
							PH_SKIPSIZE: begin
								if (sts.w_msb) begin
									cmd.emit_rej = 1'b1;
									cmd.err = wavhp_pkg::ERR_BAD_SIZE;
									phase_d = PH_HALT;
								end else begin
									cmd.skip_from_size = 1'b1;
									if (!sts.w_zero) begin
										phase_d = PH_SKIP;
									end else begin
										cmd.inc_chunks = 1'b1;
										if (sts.chunk_hit) begin
											cmd.emit_rej = 1'b1;
											cmd.err = wavhp_pkg::ERR_NO_DATA;
											phase_d = PH_HALT;
										end else begin
											phase_d = PH_ID;
										end
									end
								end
							end
							PH_DATASIZE: begin
								if (sts.hdr_err != wavhp_pkg::ERR_NONE) begin
									cmd.emit_rej = 1'b1;
									cmd.err = sts.hdr_err;
									phase_d = PH_HALT;
								end else begin
									cmd.ld_len = 1'b1;
									phase_d = PH_DIV1;
								end
							end
							default: phase_d = PH_HALT;
						endcase
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			pos_q <= 3'd0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
		end
	end

endmodule

// ----- rtl/wavhp_dp.sv -----
// Datapath: word assembly, header fields, chunk counters, sample count, output register.
module wavhp_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  wavhp_pkg::cmd_t  cmd,
	output wavhp_pkg::sts_t  sts,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	output logic [7:0]       limit,
	wavhp_out_if.source      result
);

	logic [31:0] word_q, word_base, w;
	logic [31:0] skip_q, fmtrem_q, fmt_even, size_even;
	logic [7:0]  chunks_q, limit_q, chunks_inc;
	logic [15:0] tag_q, ch_q, bits_q, align_q;
	logic [31:0] rate_q, avg_q, len_q, q3_q, base, count;
	logic [23:0] smp_q;
	logic [63:0] prod;
	logic [2:0]  nb, smp_n;
	logic [1:0]  shamt;
	logic [31:0] smp_v;
	logic        out_valid_q;

	assign limit = limit_q;

	always_comb begin
		word_base = cmd.restart ? 32'd0 : word_q;
		if (cmd.big) w = {word_base[23:0], data_byte};
		else w = word_base | ({24'd0, data_byte} << {cmd.pos[1:0], 3'b000});
		fmt_even = w + {31'd0, w[0]};
		size_even = w + {31'd0, w[0]};
		chunks_inc = (chunks_q == 8'hFF) ? chunks_q : chunks_q + 8'd1;

		nb = bits_q[5:3];
		smp_n = (bits_q[15:3] == 13'd0 || bits_q[15:3] > 13'd4) ? 3'd1 : nb;

		sts.is_riff = w == wavhp_pkg::ID_RIFF;
		sts.is_wave = w == wavhp_pkg::ID_WAVE;
		sts.is_fmt = w == wavhp_pkg::ID_FMT;
		sts.is_data = w == wavhp_pkg::ID_DATA;
		sts.w_msb = w[31];
		sts.fmt_short = fmt_even < 32'd16;
		sts.ext_ok = (fmtrem_q >= 32'd10) && (tag_q == wavhp_pkg::TAG_EXT);
		sts.fmt_zero = fmtrem_q == 32'd0;
		sts.w_zero = w == 32'd0;
		sts.skip_last = skip_q <= 32'd1;
		sts.chunk_hit = chunks_inc >= limit_q;
		sts.limit_zero = limit_q == 8'd0;
		if (ch_q != 16'd1 && ch_q != 16'd2) sts.hdr_err = wavhp_pkg::ERR_CHANNELS;
		else if (bits_q != 16'd8 && bits_q != 16'd16 && bits_q != 16'd24 && bits_q != 16'd32)
			sts.hdr_err = wavhp_pkg::ERR_BITS;
		else if (tag_q != wavhp_pkg::TAG_PCM) sts.hdr_err = wavhp_pkg::ERR_NOT_PCM;
		else sts.hdr_err = wavhp_pkg::ERR_NONE;
		sts.smp_n = smp_n;
		sts.out_free = !out_valid_q || result.ready;

		prod = {32'd0, len_q} * {31'd0, wavhp_pkg::RECIP3[32:0]};
		unique case (nb)
			3'd2: shamt = 2'd1;
			3'd4: shamt = 2'd2;
			default: shamt = 2'd0;
		endcase
		base = (nb == 3'd3) ? q3_q : len_q;
		count = base >> ({1'b0, shamt} + {2'd0, ch_q[1]});

		unique case (smp_n)
			3'd2: smp_v = {data_byte, smp_q[7:0], 16'd0};
			3'd3: smp_v = {data_byte, smp_q[15:0], 8'd0};
			3'd4: smp_v = {data_byte, smp_q[23:0]};
			default: smp_v = {data_byte ^ wavhp_pkg::SMP_FLIP, wavhp_pkg::SMP_FILL, 16'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= wavhp_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			word_q <= '0;
			skip_q <= '0;
			fmtrem_q <= '0;
			chunks_q <= '0;
			tag_q <= '0;
			ch_q <= '0;
			bits_q <= '0;
			rate_q <= '0;
			avg_q <= '0;
			align_q <= '0;
			smp_q <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			if (cmd.restart) begin
				skip_q <= '0;
				fmtrem_q <= '0;
				chunks_q <= '0;
				tag_q <= '0;
				ch_q <= '0;
				bits_q <= '0;
				rate_q <= '0;
				avg_q <= '0;
				align_q <= '0;
				smp_q <= '0;
			end
			if (cmd.acc) word_q <= cmd.done ? 32'd0 : w;
			if (cmd.ld_fmtrem) fmtrem_q <= fmt_even - 32'd16;
			if (cmd.sub10) fmtrem_q <= fmtrem_q - 32'd10;
			if (cmd.ld_tag) tag_q <= w[15:0];
			if (cmd.ld_ch) ch_q <= w[15:0];
			if (cmd.ld_rate) rate_q <= w;
			if (cmd.ld_avg) avg_q <= w;
			if (cmd.ld_align) align_q <= w[15:0];
			if (cmd.ld_bits) bits_q <= w[15:0];
			if (cmd.skip_from_fmt) skip_q <= fmtrem_q;
			if (cmd.skip_from_size) skip_q <= size_even;
			if (cmd.dec_skip && skip_q != 32'd0) skip_q <= skip_q - 32'd1;
			if (cmd.clr_chunks) chunks_q <= '0;
			if (cmd.inc_chunks) chunks_q <= chunks_inc;
			if (cmd.smp_acc) smp_q <= smp_q | ({16'd0, data_byte} << {cmd.pos[1:0], 3'b000});
			if (cmd.emit_smp || cmd.emit_hdr) smp_q <= '0;
			if (cmd.emit_smp || cmd.emit_hdr || cmd.emit_rej) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_len) len_q <= w;
		if (cmd.mul) q3_q <= {1'b0, prod[63:33]};
		if (cmd.emit_smp || cmd.emit_hdr || cmd.emit_rej) begin
			result.result_kind <= cmd.emit_smp ? wavhp_pkg::KIND_SAMPLE :
				(cmd.emit_hdr ? wavhp_pkg::KIND_HDR : wavhp_pkg::KIND_REJ);
			result.error_code <= cmd.emit_rej ? cmd.err : wavhp_pkg::ERR_NONE;
			result.sample_value <= cmd.emit_smp ? smp_v : 32'd0;
			result.channel_count <= cmd.emit_hdr ? ch_q[1:0] : 2'd0;
			result.sample_bits <= cmd.emit_hdr ? bits_q[5:0] : 6'd0;
			result.sample_rate <= cmd.emit_hdr ? rate_q : 32'd0;
			result.avg_byte_rate <= cmd.emit_hdr ? avg_q : 32'd0;
			result.block_alignment <= cmd.emit_hdr ? align_q : 16'd0;
			result.data_length <= cmd.emit_hdr ? len_q : 32'd0;
			result.sample_count <= cmd.emit_hdr ? count : 32'd0;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// ----- rtl/wav_header_parse_and_sample_unpack.sv -----
// Top level: WAV header parser and PCM sample unpacker with APB configuration port.
//   channel  | dir | handshake     | payload
//   stream   | in  | valid/ready   | data_byte, start_of_file
//   result   | out | valid/ready   | result_kind .. sample_count
//   apb      | in  | psel/penable  | chunk_limit at byte address 0
// One byte per cycle while the output register is free and the parser is not busy;
// after the data size, PH_DIV1/PH_DIV2 form the sample count (times 1/3, then shift).
// Results sit in an output register; a new byte is taken while one is being read out.
// Reset: parse phase and fields cleared, chunk_limit 20; start_of_file restarts parsing.
module wav_header_parse_and_sample_unpack (
	input  logic         clk,
	input  logic         arst_n,
	wavhp_in_if.sink     stream,
	wavhp_out_if.source  result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	wavhp_pkg::cmd_t cmd;
	wavhp_pkg::sts_t sts;
	logic            busy, go, cfg_we;
	logic [7:0]      limit;

	assign stream.ready = !busy && sts.out_free;
	assign go = stream.valid && stream.ready;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {24'd0, limit};

	wavhp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.sof(stream.start_of_file),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	wavhp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(stream.data_byte),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_data(pwdata[7:0]),
		.limit(limit),
		.result(result)
	);

endmodule

// ----- test/tb_wav_header_parse_and_sample_unpack.sv -----
// Testbench for the WAV header parser and sample unpacker: random and directed files, self-checking.
module tb_wav_header_parse_and_sample_unpack;

	typedef struct packed {
		logic [7:0] b;
		logic       sof;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  err;
		logic [31:0] smp;
		logic [1:0]  ch;
		logic [5:0]  bits;
		logic [31:0] rate;
		logic [31:0] avg;
		logic [15:0] align;
		logic [31:0] len;
		logic [31:0] cnt;
	} wav_result_t;

	typedef enum logic [4:0] {
		S_RIFF, S_FLEN, S_WAVE, S_ID, S_FMTSIZE, S_TAG, S_CH, S_RATE, S_AVG, S_ALIGN,
		S_BITS, S_EXTSKIP, S_EXTTAG, S_SKIPSIZE, S_SKIP, S_DATASIZE, S_SAMPLES, S_HALT
	} parse_state_t;

	localparam int TIMEOUT_CYCLES = 2000000;
	localparam logic [2:0] ADDR_CHUNK_LIMIT = 3'd0;

	logic clk = 0;
	logic arst_n = 0;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	wavhp_in_if  sin();
	wavhp_out_if sout();

	wav_header_parse_and_sample_unpack DUT (
		.clk(clk), .arst_n(arst_n), .stream(sin.sink), .result(sout.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	byte_item_t  byte_stream[$];
	wav_result_t expected_results[$];
	int head = 0;
	int fails = 0;
	int n_hdr = 0, n_rej = 0, n_smp = 0;
	int cycles = 0;

	// parser model state
	parse_state_t st;
	logic [2:0]  pos;
	logic [31:0] wasm, skip_rem, fmt_rem;
	logic [7:0]  chunks, limit;
	logic [15:0] tag, chans, bits, align;
	logic [31:0] rate, avg;
	logic [23:0] sasm;

	function automatic void parser_clear();
		st = S_RIFF; pos = 0; wasm = 0; skip_rem = 0; fmt_rem = 0; chunks = 0;
		tag = 0; chans = 0; bits = 0; rate = 0; avg = 0; align = 0; sasm = 0;
	endfunction

	function automatic bit grab(input logic [7:0] b, input int n, input bit big,
			output logic [31:0] w);
		if (big)
			wasm = {wasm[23:0], b};
		else
			wasm = wasm | (32'(b) << (8 * pos[1:0]));
		pos = pos + 3'd1;
		w = wasm;
		if (pos >= n) begin
			wasm = 0;
			pos = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic void reject(input logic [3:0] code);
		wav_result_t r;
		r = '0;
		r.kind = wavhp_pkg::KIND_REJ;
		r.err = code;
		st = S_HALT;
		expected_results.push_back(r);
	endfunction

	function automatic void chunk_done();
		if (chunks < 8'd255)
			chunks = chunks + 8'd1;
		if (chunks >= limit)
			reject(wavhp_pkg::ERR_NO_DATA);
		else
			st = S_ID;
	endfunction

	function automatic void skip_or_done();
		if (skip_rem == 0)
			chunk_done();
		else
			st = S_SKIP;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic sof);
		logic [31:0] w, e, v;
		wav_result_t r;
		int n;
		r = '0;
		if (sof)
			parser_clear();
		case (st)
			S_RIFF: if (grab(b, 4, 1, w)) begin
				if (w != wavhp_pkg::ID_RIFF) reject(wavhp_pkg::ERR_NOT_RIFF);
				else st = S_FLEN;
			end
			S_FLEN: if (grab(b, 4, 0, w)) st = S_WAVE;
			S_WAVE: if (grab(b, 4, 1, w)) begin
				if (w != wavhp_pkg::ID_WAVE) reject(wavhp_pkg::ERR_NOT_WAVE);
				else begin
					chunks = 0;
					if (limit == 0) reject(wavhp_pkg::ERR_NO_DATA);
					else st = S_ID;
				end
			end
			S_ID: if (grab(b, 4, 1, w))
				st = (w == wavhp_pkg::ID_FMT) ? S_FMTSIZE :
					(w == wavhp_pkg::ID_DATA) ? S_DATASIZE : S_SKIPSIZE;
			S_FMTSIZE: if (grab(b, 4, 0, w)) begin
				e = w + {31'd0, w[0]};
				if (w[31] || e < 16) reject(wavhp_pkg::ERR_FMT_SHORT);
				else begin
					fmt_rem = e - 16;
					st = S_TAG;
				end
			end
			S_TAG: if (grab(b, 2, 0, w)) begin tag = w[15:0]; st = S_CH; end
			S_CH: if (grab(b, 2, 0, w)) begin chans = w[15:0]; st = S_RATE; end
			S_RATE: if (grab(b, 4, 0, w)) begin rate = w; st = S_AVG; end
			S_AVG: if (grab(b, 4, 0, w)) begin avg = w; st = S_ALIGN; end
			S_ALIGN: if (grab(b, 2, 0, w)) begin align = w[15:0]; st = S_BITS; end
			S_BITS: if (grab(b, 2, 0, w)) begin
				bits = w[15:0];
				if (fmt_rem >= 10 && tag == wavhp_pkg::TAG_EXT) begin
					fmt_rem = fmt_rem - 10;
					st = S_EXTSKIP;
				end else begin
					skip_rem = fmt_rem;
					skip_or_done();
				end
			end
			S_EXTSKIP: begin
				pos = pos + 3'd1;
				if (pos == 0) st = S_EXTTAG;
			end
			S_EXTTAG: if (grab(b, 2, 0, w)) begin
				tag = w[15:0];
				skip_rem = fmt_rem;
				skip_or_done();
			end
			S_SKIPSIZE: if (grab(b, 4, 0, w)) begin
				if (w[31]) reject(wavhp_pkg::ERR_BAD_SIZE);
				else begin
					skip_rem = w + {31'd0, w[0]};
					skip_or_done();
				end
			end
			S_SKIP: begin
				if (skip_rem > 0) skip_rem = skip_rem - 1;
				if (skip_rem == 0) chunk_done();
			end
			S_DATASIZE: if (grab(b, 4, 0, w)) begin
				if (chans != 1 && chans != 2) reject(wavhp_pkg::ERR_CHANNELS);
				else if (bits != 8 && bits != 16 && bits != 24 && bits != 32)
					reject(wavhp_pkg::ERR_BITS);
				else if (tag != wavhp_pkg::TAG_PCM) reject(wavhp_pkg::ERR_NOT_PCM);
				else begin
					st = S_SAMPLES;
					pos = 0;
					sasm = 0;
					r.kind = wavhp_pkg::KIND_HDR;
					r.ch = chans[1:0];
					r.bits = bits[5:0];
					r.rate = rate;
					r.avg = avg;
					r.align = align;
					r.len = w;
					r.cnt = w / (32'(chans) * 32'(bits / 8));
					expected_results.push_back(r);
				end
			end
			S_SAMPLES: begin
				n = bits / 8;
				if (pos + 1 < n) begin
					sasm = sasm | (24'(b) << (8 * pos[1:0]));
					pos = pos + 3'd1;
				end else begin
					if (n == 1)
						v = {b ^ wavhp_pkg::SMP_FLIP, wavhp_pkg::SMP_FILL, 16'h0};
					else
						v = ({8'h0, sasm} | (32'(b) << (8 * (n - 1)))) << (8 * (4 - n));
					pos = 0;
					sasm = 0;
					r.kind = wavhp_pkg::KIND_SAMPLE;
					r.smp = v;
					expected_results.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	// stimulus building
	function automatic void put(input logic [7:0] b, input logic sof = 0);
		byte_item_t it;
		it.b = b;
		it.sof = sof;
		byte_stream.push_back(it);
	endfunction

	function automatic void put_be32(input logic [31:0] w, input logic sof = 0);
		put(w[31:24], sof); put(w[23:16]); put(w[15:8]); put(w[7:0]);
	endfunction

	function automatic void put_le(input logic [31:0] w, input int n);
		for (int i = 0; i < n; i++)
			put(w[8*i +: 8]);
	endfunction

	function automatic void put_rand(input int n);
		for (int i = 0; i < n; i++)
			put(8'($urandom));
	endfunction

	// flaw: 0 none, 1 bad RIFF, 2 bad WAVE, 3 short fmt, 4 huge fmt, 5 huge chunk size
	// ext: 0 plain, 1 extensible with subformat, 2 extensible tag but too short
	function automatic void put_wav(input int flaw, input logic [15:0] ch, input logic [15:0] bt,
			input logic [15:0] tg, input int ext, input int extra, input int njunk,
			input bit with_fmt, input logic [31:0] dlen, input int nbytes);
		int sz;
		put_be32(flaw == 1 ? $urandom : wavhp_pkg::ID_RIFF, 1);
		put_le($urandom, 4);
		put_be32(flaw == 2 ? $urandom : wavhp_pkg::ID_WAVE);
		for (int j = 0; j < njunk; j++) begin
			put_be32(32'h4c49_5354);
			sz = $urandom_range(0, 9);
			put_le(sz, 4);
			put_rand(sz + (sz & 1));
		end
		if (flaw == 5) begin
			put_be32(32'h6a75_6e6b);
			put_le(32'h8000_0000 | $urandom, 4);
			put_rand(4);
			return;
		end
		if (with_fmt) begin
			put_be32(wavhp_pkg::ID_FMT);
			if (flaw == 3) begin
				put_le($urandom_range(0, 14), 4);
				put_rand(4);
				return;
			end
			if (flaw == 4) begin
				put_le(32'h8000_0000 | $urandom, 4);
				put_rand(4);
				return;
			end
			sz = 16 + extra + (ext == 1 ? 24 : ext == 2 ? 2 : 0);
			put_le(sz, 4);
			put_le(ext != 0 ? 32'(wavhp_pkg::TAG_EXT) : 32'(tg), 2);
			put_le(ch, 2);
			put_le($urandom, 4);
			put_le($urandom, 4);
			put_le($urandom, 2);
			put_le(bt, 2);
			if (ext == 1) begin
				put_rand(8);
				put_le(tg, 2);
				put_rand(14);
			end else if (ext == 2)
				put_rand(2);
			put_rand(extra + (extra & 1));
		end
		put_be32(wavhp_pkg::ID_DATA);
		put_le(dlen, 4);
		put_rand(nbytes);
	endfunction

	function automatic logic [15:0] pick_bits();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 40));
			1, 2: return 16'd8;
			3, 4: return 16'd16;
			5, 6: return 16'd24;
			default: return 16'd32;
		endcase
	endfunction

	function automatic void put_random_file();
		int flaw, start_len, cut;
		logic [15:0] ch, tg;
		flaw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
		ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
		tg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wavhp_pkg::TAG_PCM;
		start_len = byte_stream.size();
		put_wav(flaw, ch, pick_bits(), tg, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0,
			$urandom_range(0, 3) * 2 + ($urandom_range(0, 4) == 0), $urandom_range(0, 1),
			$urandom_range(0, 15) != 0, $urandom, $urandom_range(0, 12));
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(start_len + 1, byte_stream.size());
			while (byte_stream.size() > cut)
				void'(byte_stream.pop_back());
		end
		if ($urandom_range(0, 7) == 0)
			put_rand($urandom_range(1, 6));
	endfunction

	// clock, timeout
	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == TIMEOUT_CYCLES) begin
			$display("timeout at %0t, %0d results outstanding", $time, expected_results.size());
			$display("tb_wav_header_parse_and_sample_unpack NOT OK");
			$finish;
		end
	end

	// byte sender, bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (sin.valid && sin.ready) begin
				parse_byte(sin.data_byte, sin.start_of_file);
				head = head + 1;
			end
			if (!(sin.valid && !sin.ready)) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					sin.valid <= 0;
				end else if (head < byte_stream.size()) begin
					sin.valid <= 1;
					sin.data_byte <= byte_stream[head].b;
					sin.start_of_file <= byte_stream[head].sof;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else
						burst_left = burst_left - 1;
				end else
					sin.valid <= 0;
			end
		end
	end

	// result receiver: patterned stalls, one long hold-off once traffic is flowing
	int rx_cyc = 0, hold_left = 0, rx_mode = 0;
	bit long_hold_done = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cyc = rx_cyc + 1;
			if (rx_cyc % 170 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				sout.ready <= 0;
			end else if (!long_hold_done && head >= 150) begin
				long_hold_done = 1;
				hold_left = 500;
				sout.ready <= 0;
			end else case (rx_mode)
				0: sout.ready <= 1;
				1: sout.ready <= $urandom_range(0, 2) != 0;
				2: sout.ready <= (rx_cyc % 5) != 2;
				default: sout.ready <= $urandom_range(0, 4) == 0;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		wav_result_t exp_r, got;
		if (arst_n && sout.valid && sout.ready) begin
			got = {sout.result_kind, sout.error_code, sout.sample_value, sout.channel_count,
				sout.sample_bits, sout.sample_rate, sout.avg_byte_rate, sout.block_alignment,
				sout.data_length, sout.sample_count};
			if (expected_results.size() == 0) begin
				fails++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				exp_r = expected_results.pop_front();
				case (exp_r.kind)
					wavhp_pkg::KIND_SAMPLE: n_smp++;
					wavhp_pkg::KIND_HDR: n_hdr++;
					default: n_rej++;
				endcase
				if (got.kind != exp_r.kind) begin fails++;
					$display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind); end
				if (got.err != exp_r.err) begin fails++;
					$display("%0t: error_code exp %0d got %0d", $time, exp_r.err, got.err); end
				if (got.smp != exp_r.smp) begin fails++;
					$display("%0t: sample exp %h got %h", $time, exp_r.smp, got.smp); end
				if (got.ch != exp_r.ch) begin fails++;
					$display("%0t: channels exp %0d got %0d", $time, exp_r.ch, got.ch); end
				if (got.bits != exp_r.bits) begin fails++;
					$display("%0t: bits exp %0d got %0d", $time, exp_r.bits, got.bits); end
				if (got.rate != exp_r.rate) begin fails++;
					$display("%0t: rate exp %h got %h", $time, exp_r.rate, got.rate); end
				if (got.avg != exp_r.avg) begin fails++;
					$display("%0t: byte rate exp %h got %h", $time, exp_r.avg, got.avg); end
				if (got.align != exp_r.align) begin fails++;
					$display("%0t: align exp %h got %h", $time, exp_r.align, got.align); end
				if (got.len != exp_r.len) begin fails++;
					$display("%0t: data length exp %h got %h", $time, exp_r.len, got.len); end
				if (got.cnt != exp_r.cnt) begin fails++;
					$display("%0t: sample count exp %h got %h", $time, exp_r.cnt, got.cnt); end
			end
		end
	end

	task automatic drain();
		int guard;
		guard = 0;
		while (head < byte_stream.size() || expected_results.size() != 0)
			@(posedge clk);
		while (guard < 12) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_CHUNK_LIMIT; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		limit = v;
	endtask

	initial begin
		int target;
		logic [7:0] limits[4];
		limits = '{8'd1, 8'd255, 8'd3, 8'd20};
		sin.valid = 0; sin.data_byte = 0; sin.start_of_file = 0; sout.ready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		limit = wavhp_pkg::LIMIT_RESET;
		parser_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed files
		put_wav(0, 1, 8, wavhp_pkg::TAG_PCM, 0, 0, 0, 1, 32'd5, 6);
		put_wav(0, 1, 24, wavhp_pkg::TAG_PCM, 1, 0, 0, 1, 32'd0, 8);
		put_wav(0, 2, 32, wavhp_pkg::TAG_PCM, 0, 1, 1, 1, 32'h7fff_fff0, 8);
		put_wav(3, 1, 16, wavhp_pkg::TAG_PCM, 0, 0, 0, 1, 0, 0);
		put_wav(5, 1, 16, wavhp_pkg::TAG_PCM, 0, 0, 0, 1, 0, 0);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_limit(limits[p]);
			target = byte_stream.size() + 40;
			while (byte_stream.size() < target)
				put_random_file();
			drain();
		end

		$display("covered %0d accepted headers, %0d rejections, %0d samples", n_hdr, n_rej,
			n_smp);
		$display("chunk limits 1, 3, 20 and 255; %0d bytes streamed", byte_stream.size());
		if (fails == 0)
			$display("tb_wav_header_parse_and_sample_unpack OK");
		else
			$display("tb_wav_header_parse_and_sample_unpack NOT OK");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/wavhp_pkg.sv
rtl/wavhp_in_if.sv
rtl/wavhp_out_if.sv
rtl/wavhp_ctrl.sv
rtl/wavhp_dp.sv
rtl/wav_header_parse_and_sample_unpack.sv
test/tb_wav_header_parse_and_sample_unpack.sv
